// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every clock edge outside reset.
`define CLOOK_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks that a condition is followed by a property in the next cycle.
`define CLOOK_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== rtl/core/clook_pkg.sv =====
// Types, status codes and default sizes for the C-LOOK request scheduler.
package clook_pkg;

   localparam int CLOOK_QUEUE_DEPTH = 32;
   localparam int SECTOR_BITS       = 48;
   localparam int OCC_BITS          = 6;

   localparam logic OP_ADD      = 1'b0;
   localparam logic OP_DISPATCH = 1'b1;

   localparam logic [1:0] STATUS_ADDED      = 2'd0;
   localparam logic [1:0] STATUS_FULL       = 2'd1;
   localparam logic [1:0] STATUS_DISPATCHED = 2'd2;
   localparam logic [1:0] STATUS_EMPTY      = 2'd3;

   typedef struct packed {
      logic                   op;
      logic [SECTOR_BITS-1:0] sector;
      logic                   is_write;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [SECTOR_BITS-1:0] out_sector;
      logic                   out_is_write;
      logic [OCC_BITS-1:0]    occupancy;
   } rsp_type;

   typedef struct packed {
      logic                   is_write;
      logic [SECTOR_BITS-1:0] sector;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

endpackage

// ===== rtl/core/clook_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module clook_ram
   import clook_pkg::*;
#(
   parameter int WIDTH = ENTRY_BITS,
   parameter int DEPTH = CLOOK_QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/clook_request_scheduler_top.sv =====
// Top level of the C-LOOK disk request scheduler.
//
// Requests arrive on the req_ channel as one struct: an op bit (add or
// dispatch), a sector and a read/write bit. Every request produces exactly
// one result on the rsp_ channel: a status code, the dispatched sector and
// direction, and the queue occupancy after the request.
// The queue lives in a circular buffer in one RAM. A dispatch reads the front
// entry and advances the base pointer, passing DOUT and PUSH on its way out.
// An add walks the queue from the front, one entry per cycle through the RAM
// read port, and once the insert point is found it ripples the displaced
// entries one slot toward the tail as it goes; ST_TAIL then writes the last
// entry. An add to a full queue or a dispatch from an empty queue goes
// straight to PUSH. One request is worked on at a time.
// The result sits in an output register, so the next request is taken while
// a result still waits; a stalled receiver holds the following result in
// the block, and no further request is taken until it can move out.
// Synchronous reset empties the queue and marks the head position invalid;
// the RAM contents are not cleared.
// The occupancy field carries the low six bits of the entry count.
module clook_request_scheduler_top
   import clook_pkg::*;
#(
   parameter int QUEUE_DEPTH = CLOOK_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

`include "assert_macros.svh"

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_TAIL = 3'd2;
   localparam logic [2:0] ST_DOUT = 3'd3;
   localparam logic [2:0] ST_PUSH = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [AW-1:0]          base_ff, base_in;
   logic [SECTOR_BITS-1:0] head_ff, head_in;
   logic                   head_valid_ff, head_valid_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic                   inserted_ff, inserted_in;
   entry_type              carry_ff, carry_in;
   req_type                req_ff, req_in;
   rsp_type                res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   entry_type              wr_data;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [ENTRY_BITS-1:0]  rd_bits;
   entry_type              cur;
   entry_type              new_entry;
   logic                   e_below;
   logic                   s_above;
   logic                   s_less;
   logic                   match;
   logic                   req_xfer;
   logic [CW-1:0]          idx_next;

   // Maps a queue position onto a RAM address relative to the base pointer.
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [CW-1:0] k);
      logic [CW:0] s;
      s = (CW+1)'(b) + (CW+1)'(k);
      if (s >= (CW+1)'(QUEUE_DEPTH)) begin
         s = s - (CW+1)'(QUEUE_DEPTH);
      end
      return s[AW-1:0];
   endfunction

   clook_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_bits)
   );

   assign cur       = entry_type'(rd_bits);
   assign new_entry = '{is_write: req_ff.is_write, sector: req_ff.sector};
   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign idx_next  = idx_ff + CW'(1);

   // Insert-before rule; without a valid head every entry counts as below it.
   assign e_below = head_valid_ff ? (cur.sector < head_ff) : 1'b1;
   assign s_above = head_valid_ff && (req_ff.sector > head_ff);
   assign s_less  = req_ff.sector < cur.sector;
   assign match   = s_above ? (e_below || s_less) : (e_below && s_less);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      base_in       = base_ff;
      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      idx_in        = idx_ff;
      inserted_in   = inserted_ff;
      carry_in      = carry_ff;
      req_in        = req_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      wr_en         = 1'b0;
      wr_addr       = phys(base_ff, idx_ff);
      wr_data       = new_entry;
      rd_en         = 1'b0;
      rd_addr       = base_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // The front entry is fetched at once; both add and dispatch start there.
            rd_en = req_xfer;
            if (req_xfer) begin
               req_in      = req_payload;
               idx_in      = '0;
               inserted_in = 1'b0;
               res_in      = '{status: STATUS_ADDED, out_sector: '0, out_is_write: 1'b0,
                               occupancy: OCC_BITS'(count_ff)};
               if (req_payload.op == OP_ADD) begin
                  if (count_ff == CW'(QUEUE_DEPTH)) begin
                     res_in.status = STATUS_FULL;
                     state_in      = ST_PUSH;
                  end else if (count_ff == '0) begin
                     state_in = ST_TAIL;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_in.status = STATUS_EMPTY;
                     state_in      = ST_PUSH;
                  end else begin
                     state_in = ST_DOUT;
                  end
               end
            end
         end
         ST_SCAN: begin
            // Once the insert point is passed, each entry moves up by one slot.
            rd_en   = 1'b1;
            rd_addr = phys(base_ff, idx_next);
            if (inserted_ff) begin
               wr_en    = 1'b1;
               wr_data  = carry_ff;
               carry_in = cur;
            end else if (match) begin
               wr_en       = 1'b1;
               wr_data     = new_entry;
               carry_in    = cur;
               inserted_in = 1'b1;
            end
            idx_in = idx_next;
            if (idx_next == count_ff) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            wr_en            = 1'b1;
            wr_addr          = phys(base_ff, count_ff);
            wr_data          = inserted_ff ? carry_ff : new_entry;
            count_in         = count_ff + CW'(1);
            res_in.status    = STATUS_ADDED;
            res_in.occupancy = OCC_BITS'(count_ff + CW'(1));
            state_in         = ST_PUSH;
         end
         ST_DOUT: begin
            head_in       = cur.sector;
            head_valid_in = 1'b1;
            base_in       = (base_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : base_ff + AW'(1);
            count_in      = count_ff - CW'(1);
            res_in        = '{status: STATUS_DISPATCHED, out_sector: cur.sector,
                              out_is_write: cur.is_write,
                              occupancy: OCC_BITS'(count_ff - CW'(1))};
            state_in      = ST_PUSH;
         end
         ST_PUSH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         base_ff       <= '0;
         head_ff       <= '0;
         head_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         base_ff       <= base_in;
         head_ff       <= head_in;
         head_valid_ff <= head_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      inserted_ff <= inserted_in;
      carry_ff    <= carry_in;
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `CLOOK_ASSERT(a_count_bound, count_ff <= CW'(QUEUE_DEPTH), "entry count above queue depth")
   `CLOOK_ASSERT(a_no_idle_write, (state_ff == ST_IDLE || state_ff == ST_PUSH) |-> !wr_en,
      "queue RAM written outside an add")
   `CLOOK_ASSERT_NEXT(a_push_loads, state_ff == ST_PUSH && (!rsp_valid_ff || rsp_ready),
      rsp_valid_ff && state_ff == ST_IDLE, "result not moved to the output register")
   `CLOOK_ASSERT(a_added_count, (state_ff == ST_PUSH && res_ff.status == STATUS_ADDED)
      |-> count_ff != '0, "request added but queue is empty")

endmodule
